>>> src/bounded_partition_counter_macros.svh
// assertion macros shared by the partition counter rtl
`ifndef BOUNDED_PARTITION_COUNTER_MACROS_SVH
`define BOUNDED_PARTITION_COUNTER_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define BPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc check failed");

// next-cycle implication, checked at every rising edge out of reset
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc check failed");

`endif

>>> src/bpc_pkg.sv
// shared widths, defaults and sequencer states of the partition counter
package bpc_pkg;

  localparam int TOTAL_W       = 8;
  localparam int LIMIT_W       = 8;
  localparam int COUNT_W       = 64;
  localparam int MAX_TOTAL_DEF = 255;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_FETCH  = 6'b010000,
    ST_LOAD   = 6'b100000
  } bpc_state_t;

endpackage

>>> src/bpc_in_if.sv
// request channel carrying the total and the part limit
interface bpc_in_if;
  import bpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_amount;
  logic [LIMIT_W-1:0] part_limit;

  modport source (output valid, output total_amount, output part_limit, input ready);
  modport sink   (input valid, input total_amount, input part_limit, output ready);
endinterface

>>> src/bpc_out_if.sv
// result channel carrying the partition count
interface bpc_out_if;
  import bpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] way_count;

  modport source (output valid, output way_count, input ready);
  modport sink   (input valid, input way_count, output ready);
endinterface

>>> src/bounded_partition_counter.sv
// partition counter: one-row count table swept by a shared 64-bit adder
//
//   channel   dir  payload                         handshake
//   in_req    in   total_amount[8], part_limit[8]  valid/ready
//   out_req   out  way_count[64]                   valid/ready
//
// T is the total and L the part limit; parts run from 1 to min(L,T).
// the single 64-bit adder does one table update per cycle, read-after-write
// on the table is covered by forwarding the last sum.
// every item with T <= MAX_TOTAL first clears entries 0..T, one per cycle.
// reset is synchronous, active low; a held result stalls only the final load.
module bounded_partition_counter #(
  parameter int MAX_TOTAL = bpc_pkg::MAX_TOTAL_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bpc_in_if.sink        in_req,
  bpc_out_if.source     out_req
);
  import bpc_pkg::*;

  localparam int DEPTH = MAX_TOTAL + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (AW > TOTAL_W) ? AW : TOTAL_W;

  typedef logic [AW-1:0]      addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  // control state
  bpc_state_t st_r, st_nxt;
  addr_t      total_r, total_nxt;
  addr_t      top_r, top_nxt;
  addr_t      r_r, r_nxt;
  addr_t      s_r, s_nxt;
  logic       zero_r, zero_nxt;
  logic       p_vld_r, p_vld_nxt;
  logic       out_valid_r, out_valid_nxt;

  // payload state
  addr_t      p_addr_r;
  logic       fwd_a_r, fwd_b_r;
  count_t     last_sum_r;
  count_t     rd_a_r, rd_b_r;
  count_t     out_word_r, out_word_nxt;

  // table memory
  count_t     mem [DEPTH];

  logic       rd_en;
  addr_t      rd_addr_a, rd_addr_b;
  logic       wr_en;
  addr_t      wr_addr;
  count_t     wr_data;
  count_t     sum;
  logic       issue;
  logic [CW-1:0] in_total_w, in_limit_w, in_top_w;

  assign in_req.ready      = (st_r == ST_IDLE);
  assign out_req.valid     = out_valid_r;
  assign out_req.way_count = out_word_r;

  // widen the request fields for the bound check and the part cap
  assign in_total_w = CW'(in_req.total_amount);
  assign in_limit_w = CW'(in_req.part_limit);
  assign in_top_w   = (in_limit_w < in_total_w) ? in_limit_w : in_total_w;

  // shared adder with forwarding of the sum written in the previous cycle
  assign sum = (fwd_a_r ? last_sum_r : rd_a_r) + (fwd_b_r ? last_sum_r : rd_b_r);

  // read ports: update reads entry r and entry r-s, fetch reads the answer
  assign issue     = (st_r == ST_UPDATE);
  assign rd_en     = issue || (st_r == ST_FETCH);
  assign rd_addr_a = issue ? r_r : total_r;
  assign rd_addr_b = r_r - s_r;

  // write port: clear sweep or the update stage, never both at once
  assign wr_en   = (st_r == ST_CLEAR) || p_vld_r;
  assign wr_addr = (st_r == ST_CLEAR) ? r_r : p_addr_r;
  assign wr_data = (st_r == ST_CLEAR) ? ((r_r == '0) ? count_t'(1) : '0) : sum;

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    total_nxt     = total_r;
    top_nxt       = top_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    zero_nxt      = zero_r;
    p_vld_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_req.ready;
    out_word_nxt  = out_word_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          total_nxt = AW'(in_total_w);
          top_nxt   = AW'(in_top_w);
          r_nxt     = '0;
          if (in_total_w > CW'(MAX_TOTAL)) begin
            zero_nxt = 1'b1;
            st_nxt   = ST_LOAD;
          end else begin
            zero_nxt = 1'b0;
            st_nxt   = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (r_r == total_r) begin
          if (top_r == '0) begin
            st_nxt = ST_FETCH;
          end else begin
            s_nxt  = addr_t'(1);
            r_nxt  = addr_t'(1);
            st_nxt = ST_UPDATE;
          end
        end else begin
          r_nxt = r_r + addr_t'(1);
        end
      end
      ST_UPDATE: begin
        p_vld_nxt = 1'b1;
        if (r_r == total_r) begin
          if (s_r == top_r) begin
            st_nxt = ST_DRAIN;
          end else begin
            s_nxt = s_r + addr_t'(1);
            r_nxt = s_r + addr_t'(1);
          end
        end else begin
          r_nxt = r_r + addr_t'(1);
        end
      end
      ST_DRAIN: begin
        st_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_req.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = zero_r ? '0 : rd_a_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      total_r     <= '0;
      top_r       <= '0;
      r_r         <= '0;
      s_r         <= '0;
      zero_r      <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      total_r     <= total_nxt;
      top_r       <= top_nxt;
      r_r         <= r_nxt;
      s_r         <= s_nxt;
      zero_r      <= zero_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // update pipeline payload and result register
  always_ff @(posedge clk) begin
    if (issue) begin
      p_addr_r <= r_r;
      fwd_a_r  <= p_vld_r && (p_addr_r == r_r);
      fwd_b_r  <= p_vld_r && (p_addr_r == rd_addr_b);
    end
    if (p_vld_r) begin
      last_sum_r <= sum;
    end
    out_word_r <= out_word_nxt;
  end

  // table memory, one write and two registered reads per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // checks
`include "bounded_partition_counter_macros.svh"

  `BPC_ASSERT_NOW(a_no_update_during_clear, st_r == ST_CLEAR, !p_vld_r)
  `BPC_ASSERT_NOW(a_update_in_range, st_r == ST_UPDATE, (r_r >= s_r) && (r_r <= total_r) && (s_r <= top_r) && (s_r != '0))
  `BPC_ASSERT_NEXT(a_result_only_from_load, !out_valid_r && (st_r != ST_LOAD), !out_valid_r)
  `BPC_ASSERT_NEXT(a_drain_empties_pipe, st_r == ST_DRAIN, !p_vld_r && (st_r == ST_FETCH))

endmodule
